FILE: rtl/tfst_pkg.sv
// ----------------------------------------------------------------------------
// tfst_pkg: shared types and constants of the TCP flow state tracker
// Holds the flow table geometry, the TCP flag positions, the flow state codes,
// the controller states and the structs that pass between the modules.
// ----------------------------------------------------------------------------
package tfst_pkg;

    // Number of flow entries; a power of two, so the flow index wraps by
    // keeping its low bits.
    localparam int FLOW_ENTRIES = 1024;
    localparam int FLOW_IDX_W   = $clog2(FLOW_ENTRIES);

    localparam int FLOW_INDEX_W = 10;
    localparam int WORD_W       = 32;
    localparam int COUNT_W      = 16;
    localparam int MINPKT_W     = 8;

    localparam logic [MINPKT_W-1:0] MINPKT_RESET = 8'd5;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

    // Positions of the flags in the tcp_flags field.
    localparam int FLAG_FIN = 0;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_RST = 2;
    localparam int FLAG_ACK = 3;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_OPEN   = 1'b1;

    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 24;

    typedef logic [FLOW_IDX_W-1:0] t_idx;

    typedef enum logic [2:0] {
        FS_NEW       = 3'd0,
        FS_CONN      = 3'd1,
        FS_ESTAB     = 3'd2,
        FS_HALFCLOSE = 3'd3,
        FS_CLOSE     = 3'd4,
        FS_RESET     = 3'd5
    } t_conn_state;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_ctrl_state;

    // One packet item as it arrives on the input stream.
    typedef struct packed {
        logic                    opcode;
        logic [FLOW_INDEX_W-1:0] flow_index;
        logic [1:0]              direction;
        logic [3:0]              tcp_flags;
        logic [WORD_W-1:0]       seq_number;
        logic [WORD_W-1:0]       ack_number;
        logic [WORD_W-1:0]       timestamp;
        logic [WORD_W-1:0]       packets_inbound;
        logic [WORD_W-1:0]       packets_outbound;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [2:0]         conn_state;
        logic [COUNT_W-1:0] lengthen_count;
        logic               lengthened_now;
        logic               reset_seen;
    } t_result;

    // One row of the flow table: the whole tracker of one flow.
    typedef struct packed {
        logic [2:0]              state_code;
        logic [1:0]              syn_seen;
        logic [1:0]              fin_seen;
        logic                    rst_flag;
        logic [COUNT_W-1:0]      lengthen_total;
        logic [1:0][WORD_W-1:0]  dir_sequence;
        logic [1:0][WORD_W-1:0]  dir_first_time;
    } t_row;

    // Controller to datapath.
    typedef struct packed {
        logic load;   // capture the input item and start the table read
        logic exec;   // write the updated row back and load the result
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;   // the result register can take a new result
    } t_status;

    function automatic t_idx flow_slot(input logic [FLOW_INDEX_W-1:0] flow_index);
        return t_idx'(flow_index);
    endfunction

endpackage

FILE: rtl/tfst_ctrl.sv
// ----------------------------------------------------------------------------
// tfst_ctrl: sequencing controller of the TCP flow state tracker
// Takes an item, waits for the registered table read, then commits the row
// and the result once the result register is free.
// ----------------------------------------------------------------------------
module tfst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tfst_pkg::t_status  i_status,
    output tfst_pkg::t_cmd     o_cmd
);

    tfst_pkg::t_ctrl_state r_state;
    tfst_pkg::t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfst_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tfst_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tfst_pkg::ST_EXEC;
                end
            end
            tfst_pkg::ST_EXEC: begin
                if (i_status.out_free) begin
                    n_state = tfst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tfst_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            tfst_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            tfst_pkg::ST_EXEC: begin
                o_cmd.exec = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/tfst_dp.sv
// ----------------------------------------------------------------------------
// tfst_dp: datapath of the TCP flow state tracker
// Holds the flow table, the item register, the threshold register, the
// update logic of one flow row and the result register.
// ----------------------------------------------------------------------------
module tfst_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tfst_pkg::MINPKT_W-1:0]   i_cfg_wdata,
    input  tfst_pkg::t_item                 i_item,
    input  tfst_pkg::t_cmd                  i_cmd,
    output tfst_pkg::t_status               o_status,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output tfst_pkg::t_result               o_result
);

    tfst_pkg::t_row  mem_table [tfst_pkg::FLOW_ENTRIES];

    tfst_pkg::t_item                 r_item;
    tfst_pkg::t_row                  r_rd_row;
    logic [tfst_pkg::MINPKT_W-1:0]   r_min_pkts;
    logic                            r_out_valid;
    tfst_pkg::t_result               r_result;

    tfst_pkg::t_idx                  item_slot;
    tfst_pkg::t_row                  n_row;
    logic                            n_counted;
    logic                            dir;
    logic                            dir_ok;
    logic [1:0]                      dir_bit;
    logic                            fl_fin;
    logic                            fl_syn;
    logic                            fl_rst;
    logic                            fl_ack;
    logic [tfst_pkg::WORD_W-1:0]     seq_dist;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pkts <= tfst_pkg::MINPKT_RESET;
        end else if (i_cfg_we) begin
            r_min_pkts <= i_cfg_wdata;
        end
    end

    // Item capture and registered table read in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item   <= i_item;
            r_rd_row <= mem_table[tfst_pkg::flow_slot(i_item.flow_index)];
        end
    end

    assign item_slot = tfst_pkg::flow_slot(r_item.flow_index);

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            mem_table[item_slot] <= n_row;
        end
    end

    assign dir     = r_item.direction[0];
    assign dir_ok  = !r_item.direction[1];
    assign dir_bit = dir ? 2'b10 : 2'b01;
    assign fl_fin  = r_item.tcp_flags[tfst_pkg::FLAG_FIN];
    assign fl_syn  = r_item.tcp_flags[tfst_pkg::FLAG_SYN];
    assign fl_rst  = r_item.tcp_flags[tfst_pkg::FLAG_RST];
    assign fl_ack  = r_item.tcp_flags[tfst_pkg::FLAG_ACK];

    // Row update. Flags are recorded first; the state moves and the
    // lengthening test then look at the recorded flags and sequence.
    always_comb begin
        n_row     = r_rd_row;
        n_counted = 1'b0;
        seq_dist  = '0;
        if (r_item.opcode == tfst_pkg::OP_OPEN) begin
            n_row                = '0;
            n_row.state_code     = tfst_pkg::FS_NEW;
            if (dir_ok) begin
                n_row.dir_sequence[dir]   = r_item.seq_number;
                n_row.dir_first_time[dir] = r_item.timestamp;
                if (r_item.ack_number != '0) begin
                    n_row.dir_sequence[!dir] = r_item.ack_number;
                end
            end
        end else if (dir_ok) begin
            if (fl_fin) begin
                n_row.fin_seen = r_rd_row.fin_seen | dir_bit;
            end
            if (fl_syn) begin
                if ((r_rd_row.syn_seen & dir_bit) == 2'b00) begin
                    n_row.syn_seen = r_rd_row.syn_seen | dir_bit;
                    if (r_rd_row.dir_sequence[dir] == '0) begin
                        n_row.dir_sequence[dir] = r_item.seq_number;
                    end
                end
                if (r_rd_row.dir_first_time[dir] == '0) begin
                    n_row.dir_first_time[dir] = r_item.timestamp;
                end
            end
            if (fl_rst) begin
                n_row.rst_flag = 1'b1;
            end

            if (fl_ack && n_row.fin_seen == 2'b11) begin
                n_row.state_code = tfst_pkg::FS_CLOSE;
            end
            if (fl_fin && n_row.fin_seen != 2'b00) begin
                n_row.state_code = tfst_pkg::FS_HALFCLOSE;
            end
            if (fl_syn) begin
                if (n_row.syn_seen == 2'b11 && fl_ack) begin
                    n_row.state_code = tfst_pkg::FS_ESTAB;
                end else if (n_row.syn_seen != 2'b00) begin
                    n_row.state_code = tfst_pkg::FS_CONN;
                end
            end
            if (fl_rst) begin
                n_row.state_code = tfst_pkg::FS_RESET;
            end

            // Mid-flow SYN: sequence distance wraps modulo 2^32.
            seq_dist  = r_item.seq_number - n_row.dir_sequence[dir];
            n_counted = fl_syn && (n_row.syn_seen == 2'b11) && (seq_dist > 32'd1)
                && (r_item.packets_inbound  > tfst_pkg::WORD_W'(r_min_pkts))
                && (r_item.packets_outbound > tfst_pkg::WORD_W'(r_min_pkts));
            if (n_counted && r_rd_row.lengthen_total != tfst_pkg::COUNT_MAX) begin
                n_row.lengthen_total = r_rd_row.lengthen_total + tfst_pkg::COUNT_W'(1);
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_result.conn_state     <= n_row.state_code;
            r_result.lengthen_count <= n_row.lengthen_total;
            r_result.lengthened_now <= n_counted;
            r_result.reset_seen     <= n_row.rst_flag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

FILE: rtl/tcp_flow_state_tracker.sv
// ----------------------------------------------------------------------------
// tcp_flow_state_tracker: per-flow TCP connection state table
// Tracks SYN and FIN per direction and RST per flow for up to FLOW_ENTRIES flows, moves
// each flow through its connection states and counts mid-flow SYNs.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Signals                           | Content
//  ---------+-----------+-----------------------------------+------------------------
//  s_axis   | in        | tvalid, tready, tdata[175:0], tuser | one packet header
//  m_axis   | out       | tvalid, tready, tdata[23:0]       | one flow result
//  cfg      | in        | i_cfg_we, i_cfg_wdata[7:0]        | lengthen_min_packets
//
// In the accept cycle the flow row is read from the single-port flow table;
// in the EXEC state that follows, the updated row is written back and the
// result is loaded into the output register. That read-modify-write of one
// table port means that a new transfer is taken only once the last item has
// committed. The output register lets the next input transfer be taken while a
// result still waits; if it is still full when the next item is ready to
// commit, the commit waits. Reset is synchronous and active low; it clears
// the controller, the output valid flag and sets the threshold to 5. The
// flow table is not cleared: a flow must be opened before it is updated.
//
module tcp_flow_state_tracker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Threshold register write.
    input  logic                             i_cfg_we,
    input  logic [tfst_pkg::MINPKT_W-1:0]    i_cfg_wdata,
    // Input stream.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // From bit 0: flow_index[9:0], direction[11:10], tcp_flags[15:12],
    // seq_number[47:16], ack_number[79:48], timestamp[111:80],
    // packets_inbound[143:112], packets_outbound[175:144].
    input  logic [tfst_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // opcode: 0 update the flow, 1 open the flow.
    input  logic                             s_axis_tuser,
    // Output stream.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // From bit 0: conn_state[2:0], lengthen_count[18:3], lengthened_now[19],
    // reset_seen[20], zero fill[23:21].
    output logic [tfst_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    tfst_pkg::t_item    in_item;
    tfst_pkg::t_result  out_result;
    tfst_pkg::t_cmd     cmd;
    tfst_pkg::t_status  status;

    // Unpack the input transfer into its fields.
    always_comb begin
        in_item.opcode           = s_axis_tuser;
        in_item.flow_index       = s_axis_tdata[9:0];
        in_item.direction        = s_axis_tdata[11:10];
        in_item.tcp_flags        = s_axis_tdata[15:12];
        in_item.seq_number       = s_axis_tdata[47:16];
        in_item.ack_number       = s_axis_tdata[79:48];
        in_item.timestamp        = s_axis_tdata[111:80];
        in_item.packets_inbound  = s_axis_tdata[143:112];
        in_item.packets_outbound = s_axis_tdata[175:144];
    end

    tfst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tfst_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (out_result)
    );

    // Pack the result, first field in the lowest bits.
    assign m_axis_tdata = {3'b000,
                           out_result.reset_seen,
                           out_result.lengthened_now,
                           out_result.lengthen_count,
                           out_result.conn_state};

endmodule

FILE: sim/tb_tcp_flow_state_tracker.sv
// ----------------------------------------------------------------------------
// tb_tcp_flow_state_tracker: self-checking bench for the TCP flow state tracker
// Drives packet headers into the input stream, predicts every flow result with
// a bench-side copy of the flow table and compares each output transfer, field
// by field, against the oldest prediction. Directed cases, threshold extremes,
// a long run of lengthenings, a long output stall and random TCP sessions run
// in turn.
// ----------------------------------------------------------------------------
module tb_tcp_flow_state_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import tfst_pkg::*;

    // Direction codes of the packet item.
    localparam logic [1:0] DIR_OUT     = 2'd0;
    localparam logic [1:0] DIR_IN      = 2'd1;
    localparam logic [1:0] DIR_SKIP_LO = 2'd2;
    localparam logic [1:0] DIR_SKIP_HI = 2'd3;

    // TCP flag masks, built from the bit positions of the package.
    localparam logic [3:0] TCP_FIN = 4'b0001 << FLAG_FIN;
    localparam logic [3:0] TCP_SYN = 4'b0001 << FLAG_SYN;
    localparam logic [3:0] TCP_RST = 4'b0001 << FLAG_RST;
    localparam logic [3:0] TCP_ACK = 4'b0001 << FLAG_ACK;
    localparam logic [3:0] TCP_ALL = TCP_FIN | TCP_SYN | TCP_RST | TCP_ACK;

    localparam int RANDOM_ITEMS     = 1100;
    localparam int LENGTHEN_REPEATS = 200;
    localparam int HOLD_CYCLES      = 400;
    localparam int POOL_SIZE        = 12;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [MINPKT_W-1:0]    i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    tcp_flow_state_tracker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Bench copy of the flow table and of the threshold register. First
    // timestamps are not kept: they never reach a result.
    // ------------------------------------------------------------------------
    t_conn_state         trk_state [FLOW_ENTRIES];
    logic [1:0]          trk_syn   [FLOW_ENTRIES];
    logic [1:0]          trk_fin   [FLOW_ENTRIES];
    logic                trk_rst   [FLOW_ENTRIES];
    logic [COUNT_W-1:0]  trk_count [FLOW_ENTRIES];
    logic [WORD_W-1:0]   trk_seq   [2*FLOW_ENTRIES];
    logic [MINPKT_W-1:0] min_packets;

    // Predicted results in transfer order, oldest first.
    t_result flow_result_q [$];

    int  error_count;
    int  items_sent;   // items that the block acts on; ignored updates are left out
    bit  gaps_on;      // sender inserts random idle gaps between bursts
    int  burst_left;
    bit  hold_req;     // asks the receiver for one long stall

    // Applies one packet to the bench flow table and returns the result that
    // the block must produce for it.
    function automatic t_result track_packet(input t_item pkt);
        int unsigned        e;
        int unsigned        slot;
        logic [1:0]         dbit;
        logic [WORD_W-1:0]  seq_gap;
        logic               now;
        t_result            r;
        e    = pkt.flow_index % FLOW_ENTRIES;
        slot = 2 * e + pkt.direction[0];
        dbit = 2'b01 << pkt.direction[0];
        now  = 1'b0;
        if (pkt.opcode == OP_OPEN) begin
            trk_state[e]     = FS_NEW;
            trk_syn[e]       = 2'b00;
            trk_fin[e]       = 2'b00;
            trk_rst[e]       = 1'b0;
            trk_count[e]     = '0;
            trk_seq[2*e]     = '0;
            trk_seq[2*e + 1] = '0;
            // An open with an ignored direction still clears the entry but
            // leaves both sequences at zero.
            if (!pkt.direction[1]) begin
                trk_seq[slot] = pkt.seq_number;
                if (pkt.ack_number != '0) begin
                    trk_seq[slot ^ 1] = pkt.ack_number;
                end
            end
        end else if (!pkt.direction[1]) begin
            // Flags are recorded first, the state moves on the updated flags.
            if (pkt.tcp_flags[FLAG_FIN]) begin
                trk_fin[e] = trk_fin[e] | dbit;
            end
            if (pkt.tcp_flags[FLAG_SYN] && !(trk_syn[e] & dbit)) begin
                trk_syn[e] = trk_syn[e] | dbit;
                if (trk_seq[slot] == '0) begin
                    trk_seq[slot] = pkt.seq_number;
                end
            end
            if (pkt.tcp_flags[FLAG_RST]) begin
                trk_rst[e] = 1'b1;
            end
            if (pkt.tcp_flags[FLAG_ACK] && trk_fin[e] == 2'b11) begin
                trk_state[e] = FS_CLOSE;
            end
            if (pkt.tcp_flags[FLAG_FIN] && trk_fin[e] != 2'b00) begin
                trk_state[e] = FS_HALFCLOSE;
            end
            if (pkt.tcp_flags[FLAG_SYN]) begin
                if (trk_syn[e] == 2'b11 && pkt.tcp_flags[FLAG_ACK]) begin
                    trk_state[e] = FS_ESTAB;
                end else if (trk_syn[e] != 2'b00) begin
                    trk_state[e] = FS_CONN;
                end
            end
            if (pkt.tcp_flags[FLAG_RST]) begin
                trk_state[e] = FS_RESET;
            end
            // A mid-flow SYN counts when it moves the sequence on by more than
            // one (modulo 2^32) and both packet counts exceed the threshold.
            seq_gap = pkt.seq_number - trk_seq[slot];
            now = pkt.tcp_flags[FLAG_SYN] && trk_syn[e] == 2'b11 && seq_gap > 32'd1 &&
                  pkt.packets_inbound > WORD_W'(min_packets) &&
                  pkt.packets_outbound > WORD_W'(min_packets);
            if (now && trk_count[e] != COUNT_MAX) begin
                trk_count[e] = trk_count[e] + 1'b1;
            end
        end
        r.conn_state     = trk_state[e];
        r.lengthen_count = trk_count[e];
        r.lengthened_now = now;
        r.reset_seen     = trk_rst[e];
        return r;
    endfunction

    function automatic t_item make_pkt(input logic op, input logic [FLOW_INDEX_W-1:0] idx,
                                       input logic [1:0] dir, input logic [3:0] flags,
                                       input logic [WORD_W-1:0] seq, ack, ts, pin, pout);
        t_item p;
        p.opcode           = op;
        p.flow_index       = idx;
        p.direction        = dir;
        p.tcp_flags        = flags;
        p.seq_number       = seq;
        p.ack_number       = ack;
        p.timestamp        = ts;
        p.packets_inbound  = pin;
        p.packets_outbound = pout;
        return p;
    endfunction

    // Packet counts cluster around the threshold so that both sides of the
    // comparison are hit often.
    function automatic logic [WORD_W-1:0] pick_count();
        case ($urandom_range(0, 5))
            0: return WORD_W'(min_packets);
            1: return WORD_W'(min_packets) + 1;
            2: return $urandom_range(0, 300);
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock, watchdog and receiver.
    // ------------------------------------------------------------------------
    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // About 1500 items, plus idle gaps, output stalls and the long hold, stay
    // well under a quarter of this limit.
    initial begin : watchdog
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // The receiver switches between always ready, random ready, mostly
    // stalled and a fixed toggle pattern, in segments of random length. When
    // asked, it holds tready low for one long stall so that the block
    // fills up and stalls its input.
    initial begin : receiver
        int          seg_left;
        int          hold_left;
        int unsigned mode;
        seg_left      = 0;
        hold_left     = 0;
        mode          = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(4, 64);
                    mode     = $urandom_range(0, 3);
                end
                seg_left--;
                case (mode)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = 1'($urandom_range(0, 1));
                    2: m_axis_tready = ($urandom_range(0, 3) == 0);
                    default: m_axis_tready = seg_left[1];
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every output transfer is matched against the oldest
    // prediction. tdata from bit 0: conn_state, lengthen_count,
    // lengthened_now, reset_seen.
    // ------------------------------------------------------------------------
    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (flow_result_q.size() == 0) begin
                $display("%0t ns: result transfer with none expected, expected none, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                want = flow_result_q.pop_front();
                report_field("conn_state", want.conn_state, m_axis_tdata[2:0]);
                report_field("lengthen_count", want.lengthen_count, m_axis_tdata[18:3]);
                report_field("lengthened_now", want.lengthened_now, m_axis_tdata[19]);
                report_field("reset_seen", want.reset_seen, m_axis_tdata[20]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Inputs change on the falling edge; the transfer is taken at the
    // rising edge where tvalid and tready are both high, and only then is the
    // result predicted. tvalid stays high from one item to the next inside a
    // burst; a gap lowers it between bursts.
    // ------------------------------------------------------------------------
    task automatic send_item(input t_item pkt);
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = pkt.opcode;
        s_axis_tdata  = {pkt.packets_outbound, pkt.packets_inbound, pkt.timestamp,
                         pkt.ack_number, pkt.seq_number, pkt.tcp_flags, pkt.direction,
                         pkt.flow_index};
        do @(posedge i_clk); while (!s_axis_tready);
        flow_result_q.push_back(track_packet(pkt));
        if (pkt.opcode == OP_OPEN || !pkt.direction[1]) begin
            items_sent++;
        end
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_update(input logic [FLOW_INDEX_W-1:0] idx, input logic [1:0] dir,
                               input logic [3:0] flags, input logic [WORD_W-1:0] seq);
        send_item(make_pkt(OP_UPDATE, idx, dir, flags, seq, $urandom, $urandom,
                           pick_count(), pick_count()));
    endtask

    task automatic send_open(input logic [FLOW_INDEX_W-1:0] idx, input logic [1:0] dir,
                             input logic [WORD_W-1:0] seq, ack);
        send_item(make_pkt(OP_OPEN, idx, dir, 4'($urandom_range(0, 15)), seq, ack, $urandom,
                           pick_count(), pick_count()));
    endtask

    // Lowers tvalid and waits until every predicted result has come back,
    // then lets the pipeline settle.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (flow_result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // The threshold is only written while nothing is in flight.
    task automatic write_threshold(input logic [MINPKT_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        min_packets = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Runs at the reset threshold of 5. Covers both table extremes, every
    // flag and state, ignored directions on open and update, a zero ack on
    // open and sequence distances of 0, 1, 2 and across the 2^32 wrap.
    task automatic test_directed();
        gaps_on = 1'b1;
        // Zero ack leaves the incoming sequence at zero.
        send_item(make_pkt(OP_OPEN, 10'd0, DIR_OUT, TCP_SYN, 32'd100, 32'd0, 32'd0, 0, 0));
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_OUT, TCP_SYN, 32'd100, 0, 1, 6, 6));
        // SYN-ACK back: incoming sequence is taken, flow becomes established.
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_IN, TCP_SYN | TCP_ACK, '1, 0, '1, 6, 6));
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_OUT, TCP_ACK, 32'd101, 0, 2, 6, 6));
        // Mid-flow SYNs: distance 2 counts, distance 1 does not.
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_OUT, TCP_SYN, 32'd102, 0, 3, 6, 6));
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_OUT, TCP_SYN, 32'd101, 0, 3, 6, 6));
        // Distance 2 across the wrap, first with too few outbound packets.
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_IN, TCP_SYN, 32'd1, 0, 4, 6, 5));
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_IN, TCP_SYN, 32'd1, 0, 4, 6, 6));
        // A sequence one below the stored one is a huge forward distance.
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_OUT, TCP_SYN | TCP_ACK, 32'd99, 0, 5, '1, '1));
        // Ignored directions change nothing.
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_SKIP_LO, TCP_ALL, '1, '1, '1, '1, '1));
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_SKIP_HI, TCP_ALL, 32'd7, 0, 0, '1, '1));
        // Teardown: FIN, FIN-ACK, final ACK, then a reset.
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_OUT, TCP_FIN, 32'd200, 0, 6, 0, 0));
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_IN, TCP_FIN | TCP_ACK, 32'd300, 0, 6, 0, 0));
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_OUT, TCP_ACK, 32'd201, 0, 7, 0, 0));
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_IN, TCP_RST, 32'd301, 0, 7, 0, 0));
        // Top entry with every field but the direction at its maximum.
        send_item(make_pkt(OP_OPEN, 10'd1023, DIR_IN, TCP_ALL, '1, '1, '1, '1, '1));
        send_item(make_pkt(OP_UPDATE, 10'd1023, DIR_IN, TCP_SYN, '1, '1, '1, '1, '1));
        send_item(make_pkt(OP_UPDATE, 10'd1023, DIR_OUT, TCP_ALL, 32'd0, '1, '1, '1, '1));
        // Open with an ignored direction zeroes both sequences.
        send_item(make_pkt(OP_OPEN, 10'd1023, DIR_SKIP_LO, 4'b0000, '1, '1, '1, 0, 0));
        send_item(make_pkt(OP_UPDATE, 10'd1023, DIR_OUT, TCP_SYN, 32'd0, 0, 0, 9, 9));
        send_item(make_pkt(OP_UPDATE, 10'd1023, DIR_IN, TCP_SYN | TCP_ACK, 32'd5, 0, 0, 9, 9));
        send_item(make_pkt(OP_OPEN, 10'd0, DIR_SKIP_HI, TCP_ALL, 32'd55, 32'd66, 0, 0, 0));
        send_item(make_pkt(OP_UPDATE, 10'd0, DIR_IN, TCP_ACK, 32'd1, 0, 0, 0, 0));
    endtask

    // Both threshold extremes, with packet counts just at and just above it.
    task automatic test_threshold_extremes();
        logic [MINPKT_W-1:0] levels [2] = '{8'd255, 8'd0};
        logic [WORD_W-1:0]   lo;
        foreach (levels[i]) begin
            write_threshold(levels[i]);
            lo = WORD_W'(levels[i]);
            send_item(make_pkt(OP_OPEN, 10'd512, DIR_OUT, 4'b0000, 32'd10, 32'd20, 1, 0, 0));
            send_item(make_pkt(OP_UPDATE, 10'd512, DIR_OUT, TCP_SYN, 32'd10, 0, 1, 0, 0));
            send_item(make_pkt(OP_UPDATE, 10'd512, DIR_IN, TCP_SYN | TCP_ACK, 32'd20, 0, 1, 0, 0));
            send_item(make_pkt(OP_UPDATE, 10'd512, DIR_OUT, TCP_SYN, 32'd12, 0, 2, lo, lo + 1));
            send_item(make_pkt(OP_UPDATE, 10'd512, DIR_OUT, TCP_SYN, 32'd12, 0, 2, lo + 1, lo));
            send_item(make_pkt(OP_UPDATE, 10'd512, DIR_OUT, TCP_SYN, 32'd12, 0, 2, lo + 1, lo + 1));
        end
    endtask

    // Drives one flow through a long run of mid-flow SYNs back to back; the
    // counter must step on each one while lengthened_now reports it.
    task automatic test_lengthen_run();
        write_threshold(8'd0);
        gaps_on = 1'b0;
        send_item(make_pkt(OP_OPEN, 10'd777, DIR_IN, 4'b0000, 32'd3000, 32'd4000, 1, 0, 0));
        send_item(make_pkt(OP_UPDATE, 10'd777, DIR_IN, TCP_SYN, 32'd3000, 0, 1, 1, 1));
        send_item(make_pkt(OP_UPDATE, 10'd777, DIR_OUT, TCP_SYN | TCP_ACK, 32'd4000, 0, 1, 1, 1));
        for (int i = 0; i < LENGTHEN_REPEATS; i++) begin
            send_item(make_pkt(OP_UPDATE, 10'd777, DIR_OUT, TCP_SYN | TCP_ACK,
                               32'd4002 + (i % 256), 0, 2, 1, 1));
        end
        gaps_on = 1'b1;
    endtask

    // The receiver stalls for a long stretch while the sender keeps offering
    // back-to-back items, so the output register fills and tready drops.
    task automatic test_backpressure();
        wait_idle();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) begin
            send_update(10'd777, 2'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), $urandom);
        end
        gaps_on = 1'b1;
    endtask

    // One well-formed TCP session on an entry: open, three-way handshake,
    // data with occasional mid-flow SYNs near the stored sequence, then a
    // FIN teardown or a reset.
    task automatic run_session(input logic [FLOW_INDEX_W-1:0] idx);
        logic [1:0]  d;
        logic [1:0]  o;
        logic [1:0]  dd;
        int unsigned k;
        d = $urandom_range(0, 1) ? DIR_IN : DIR_OUT;
        o = d ^ 2'b01;
        send_open(idx, d, $urandom, ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom);
        send_update(idx, d, TCP_SYN | (($urandom_range(0, 3) == 0) ? TCP_ACK : 4'b0000),
                    $urandom);
        send_update(idx, o, TCP_SYN | TCP_ACK, $urandom);
        send_update(idx, d, TCP_ACK, $urandom);
        repeat ($urandom_range(0, 8)) begin
            k  = $urandom_range(0, 9);
            dd = $urandom_range(0, 1) ? DIR_IN : DIR_OUT;
            if (k < 5) begin
                send_update(idx, dd, TCP_ACK, $urandom);
            end else if (k < 9) begin
                // Sequence between one below and three above the stored one.
                send_update(idx, dd, TCP_SYN | ((k % 2) ? TCP_ACK : 4'b0000),
                            trk_seq[2*idx + dd] + WORD_W'($urandom_range(0, 4)) - 1);
            end else begin
                send_update(idx, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                            $urandom);
            end
        end
        if ($urandom_range(0, 3) != 0) begin
            send_update(idx, d, TCP_FIN, $urandom);
            send_update(idx, o, TCP_FIN | TCP_ACK, $urandom);
            send_update(idx, d, TCP_ACK, $urandom);
        end else begin
            send_update(idx, 2'($urandom_range(0, 1)), TCP_RST | 4'($urandom_range(0, 15)),
                        $urandom);
        end
    endtask

    // Random traffic in four phases, each with its own threshold and its own
    // pool of flow entries. Mostly sessions, the rest is noise: random opens on any
    // entry, random flags and ignored directions on entries of the pool.
    task automatic test_random_traffic();
        logic [FLOW_INDEX_W-1:0] pool [POOL_SIZE];
        int                      start;
        start   = items_sent;
        gaps_on = 1'b1;
        for (int p = 0; p < 4; p++) begin
            case (p)
                1: write_threshold(8'd255);
                2: write_threshold(8'd0);
                default: write_threshold(MINPKT_W'($urandom_range(1, 12)));
            endcase
            foreach (pool[i]) begin
                pool[i] = FLOW_INDEX_W'($urandom_range(0, FLOW_ENTRIES - 1));
                send_open(pool[i], 2'($urandom_range(0, 3)), $urandom, $urandom);
            end
            while (items_sent < start + (p + 1) * RANDOM_ITEMS / 4) begin
                if ($urandom_range(0, 3) != 0) begin
                    run_session(pool[$urandom_range(0, POOL_SIZE - 1)]);
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        if ($urandom_range(0, 4) == 0) begin
                            send_open(FLOW_INDEX_W'($urandom_range(0, FLOW_ENTRIES - 1)),
                                      2'($urandom_range(0, 3)), $urandom, $urandom);
                        end else begin
                            send_update(pool[$urandom_range(0, POOL_SIZE - 1)],
                                        2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                                        $urandom);
                        end
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial begin : main
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        min_packets   = MINPKT_RESET;
        error_count   = 0;
        items_sent    = 0;
        gaps_on       = 1'b1;
        burst_left    = 0;
        hold_req      = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_threshold_extremes();
        test_lengthen_run();
        test_backpressure();
        test_random_traffic();

        // Drain every outstanding result before the verdict.
        wait_idle();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tfst_pkg.sv
rtl/tfst_ctrl.sv
rtl/tfst_dp.sv
rtl/tcp_flow_state_tracker.sv
sim/tb_tcp_flow_state_tracker.sv
